// ----- hdl/pidc_pkg.sv -----
`default_nettype none
package pidc_pkg;

  localparam int unsigned ErrorWidth = 8;
  localparam int unsigned QWidth     = 16;
  localparam int unsigned SumWidth   = 32;
  localparam int unsigned FracBits   = 8;
  localparam int unsigned ApbData    = 32;
  localparam int unsigned ApbAddr    = 4;

  typedef logic signed [ErrorWidth-1:0] error_t;
  typedef logic signed [QWidth-1:0]     q88_t;
  typedef logic signed [SumWidth-1:0]   q1616_t;
  typedef logic signed [QWidth:0]       diff_t;

  typedef enum logic [1:0] {
    REG_KP = 2'd0,
    REG_KI = 2'd1,
    REG_KD = 2'd2
  } reg_index_t;

  localparam q88_t KpReset = 16'sd256;
  localparam q88_t KiReset = 16'sd64;
  localparam q88_t KdReset = 16'sd128;

endpackage
`default_nettype wire

// ----- hdl/pidc_ifs.sv -----
`default_nettype none
interface pidc_sample_if;
  logic              valid;
  logic              ready;
  pidc_pkg::error_t  error_value;

  modport source(output valid, output error_value, input ready);
  modport sink(input valid, input error_value, output ready);
endinterface

interface pidc_drive_if;
  logic            valid;
  logic            ready;
  pidc_pkg::q88_t  control_output;

  modport source(output valid, output control_output, input ready);
  modport sink(input valid, input control_output, output ready);
endinterface
`default_nettype wire

// ----- hdl/pid_controller_fixed_point_unit.sv -----
// an accepted error beat goes via the stage and output registers to the drive side
// throughput: one beat per cycle while drive is ready; integral and previous error
//   update on accept; products and sum are formed between stage and output registers
// a stalled output register holds a full stage register; an empty one takes one beat
// reset (rst, synchronous): gains return to 1.0 / 0.25 / 0.5, integral and previous
//   error clear to zero, both pipeline stages empty
`default_nettype none
module pid_controller_fixed_point_unit (
  input  wire                                clk,
  input  wire                                rst,
  pidc_sample_if.sink                        sample,
  pidc_drive_if.source                       drive,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [pidc_pkg::ApbAddr-1:0]       paddr,
  input  wire  [pidc_pkg::ApbData-1:0]       pwdata,
  output logic [pidc_pkg::ApbData-1:0]       prdata,
  output logic                               pready
);
  import pidc_pkg::*;

  // configuration
  q88_t       proportional_gain;
  q88_t       integral_gain;
  q88_t       derivative_gain;
  reg_index_t reg_sel;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      proportional_gain <= KpReset;
      integral_gain     <= KiReset;
      derivative_gain   <= KdReset;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_KP:  proportional_gain <= q88_t'(pwdata[QWidth-1:0]);
        REG_KI:  integral_gain     <= q88_t'(pwdata[QWidth-1:0]);
        REG_KD:  derivative_gain   <= q88_t'(pwdata[QWidth-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_KP:  prdata = {{(ApbData-QWidth){proportional_gain[QWidth-1]}}, proportional_gain};
      REG_KI:  prdata = {{(ApbData-QWidth){integral_gain[QWidth-1]}}, integral_gain};
      REG_KD:  prdata = {{(ApbData-QWidth){derivative_gain[QWidth-1]}}, derivative_gain};
      default: prdata = '0;
    endcase
  end

  // controller state
  q1616_t integral_sum;
  q88_t   previous_error;
  q1616_t integral_sum_next;
  q88_t   error_q;
  diff_t  diff_next;
  logic   accept;
  logic   advance;

  // stage register
  logic   s1_valid;
  error_t s1_error;
  q1616_t s1_sum;
  diff_t  s1_diff;

  // output register
  logic   out_valid;
  q88_t   out_value;

  assign advance      = !out_valid || drive.ready;
  assign sample.ready = !s1_valid || advance;
  assign accept       = sample.valid && sample.ready;

  assign error_q           = {sample.error_value, {FracBits{1'b0}}};
  // error in Q16.16 is the integer sample shifted up by sixteen
  assign integral_sum_next = integral_sum
                           + {{(SumWidth-ErrorWidth-2*FracBits){sample.error_value[ErrorWidth-1]}},
                              sample.error_value, {(2*FracBits){1'b0}}};
  assign diff_next         = {error_q[QWidth-1], error_q}
                           - {previous_error[QWidth-1], previous_error};

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum   <= '0;
      previous_error <= '0;
    end else if (accept) begin
      integral_sum   <= integral_sum_next;
      previous_error <= error_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_error <= sample.error_value;
      s1_sum   <= integral_sum_next;
      s1_diff  <= diff_next;
    end
  end

  // products and sum
  q88_t                     s1_error_q;
  logic signed [31:0]       p_full;
  logic signed [47:0]       i_full;
  logic signed [32:0]       d_full;
  logic [SumWidth-1:0]      total;

  assign s1_error_q = {s1_error, {FracBits{1'b0}}};
  assign p_full     = proportional_gain * s1_error_q;
  assign i_full     = integral_gain * s1_sum;
  assign d_full     = derivative_gain * s1_diff;
  // integral product is Q24.24, floor back to Q16.16 by dropping eight bits
  assign total      = p_full[SumWidth-1:0]
                    + i_full[SumWidth+FracBits-1:FracBits]
                    + d_full[SumWidth-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_value <= q88_t'(total[QWidth+FracBits-1:FracBits]);
    end
  end

  assign drive.valid          = out_valid;
  assign drive.control_output = out_value;

  a_prev_tracks: assert property (@(posedge clk) disable iff (rst)
    accept |=> previous_error == {$past(sample.error_value), {FracBits{1'b0}}})
    else $error("previous error not updated by accepted beat");

  a_integral_tracks: assert property (@(posedge clk) disable iff (rst)
    accept |=> integral_sum == s1_sum)
    else $error("stage sum differs from integral state");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> s1_valid && $stable(s1_sum) && $stable(s1_diff))
    else $error("stage register lost data under stall");

  a_stage_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted beat not held in stage register");

  a_gain_reset: assert property (@(posedge clk)
    rst |=> proportional_gain == KpReset && integral_gain == KiReset
            && derivative_gain == KdReset)
    else $error("gains not restored by reset");

endmodule
`default_nettype wire
